[design/sle_pkg.sv]
`timescale 1ns / 1ps

package sle_pkg;

  // list size and derived widths
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int LEN_W    = 6;
  localparam int VAL_W    = 32;
  localparam int CMP_W    = (IDX_W > POS_W) ? IDX_W : POS_W;

  // operation codes
  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE_VAL = 3'd1,
    OP_REMOVE_POS = 3'd2,
    OP_FIND       = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // shared control broadcast to every cell
  typedef struct packed {
    logic                    ins_en;
    logic                    rv_en;
    logic                    rp_en;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
  } cell_ctrl_t;

  // cell index to the 5-bit position field, low bits kept
  function automatic logic [POS_W-1:0] idx_to_pos(input logic [IDX_W-1:0] idx);
    logic [POS_W+IDX_W-1:0] tmp;
    tmp = {{POS_W{1'b0}}, idx};
    return tmp[POS_W-1:0];
  endfunction

  // count to the 6-bit length field, low bits kept
  function automatic logic [LEN_W-1:0] cnt_to_len(input logic [CNT_W-1:0] cnt);
    logic [LEN_W+CNT_W-1:0] tmp;
    tmp = {{LEN_W{1'b0}}, cnt};
    return tmp[LEN_W-1:0];
  endfunction

endpackage

[design/sle_if.sv]
`timescale 1ns / 1ps

// operation channel
interface sle_in_if;
  logic                 valid;
  logic                 ready;
  sle_pkg::op_t         op;
  logic signed [31:0]   value;
  logic [4:0]           position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// result channel
interface sle_out_if;
  logic                 valid;
  logic                 ready;
  sle_pkg::status_t     status;
  logic signed [31:0]   found_value;
  logic [4:0]           found_position;
  logic [5:0]           length;
  logic                 empty_res;

  modport source (output valid, output status, output found_value, output found_position,
                  output length, output empty_res, input ready);
  modport sink   (input valid, input status, input found_value, input found_position,
                  input length, input empty_res, output ready);
endinterface

[design/sle_cell.sv]
`timescale 1ns / 1ps

module sle_cell (
  input  logic                                clk,
  input  sle_pkg::cell_ctrl_t                 ctrl,
  input  logic [sle_pkg::IDX_W-1:0]           cell_idx,
  input  logic [sle_pkg::CNT_W-1:0]           count,
  input  logic                                left_le,
  input  logic                                left_eq,
  input  logic signed [sle_pkg::VAL_W-1:0]    left_val,
  input  logic signed [sle_pkg::VAL_W-1:0]    right_val,
  output logic signed [sle_pkg::VAL_W-1:0]    entry,
  output logic                                le,
  output logic                                eq,
  output logic                                first_eq,
  output logic                                ins_here
);
  import sle_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  logic                    occupied;
  logic                    below;
  logic                    at_or_after_pos;

  // compare against the broadcast value
  always_comb begin
    occupied        = CNT_W'(cell_idx) < count;
    below           = entry_r < ctrl.value;
    le              = occupied && !(ctrl.value < entry_r);
    eq              = occupied && (entry_r == ctrl.value);
    first_eq        = eq && !left_eq;
    ins_here        = !le && left_le;
    at_or_after_pos = CMP_W'(cell_idx) >= CMP_W'(ctrl.pos);
  end

  // shift right on insert, shift left on removal
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (!le) begin
        entry_nxt = left_le ? ctrl.value : left_val;
      end
    end else if (ctrl.rv_en) begin
      if (!below) begin
        entry_nxt = right_val;
      end
    end else if (ctrl.rp_en) begin
      if (at_or_after_pos) begin
        entry_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

[design/sorted_list_engine_top.sv]
`timescale 1ns / 1ps

// channel  direction  payload
// in_ch    sink       op, value, position
// out_ch   source     status, found_value, found_position, length, empty_res
//
// one transaction per cycle while out_ch is not stalled: all cells compare and shift in the cycle the
// operation is taken, and the result appears in the output register in the next cycle
// the compare-and-shift across the whole cell chain within the taking cycle sets this rate
// reset clears the length and the output valid flag; entries stay unwritten, no clearing pass
// in_ch.ready is high while the output register is empty or being taken

module sorted_list_engine_top (
  input  logic           clk,
  input  logic           rst_n,
  sle_in_if.sink         in_ch,
  sle_out_if.source      out_ch
);
  import sle_pkg::*;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  status_t                 status_r;
  status_t                 status_nxt;
  logic signed [VAL_W-1:0] fval_r;
  logic signed [VAL_W-1:0] fval_nxt;
  logic [POS_W-1:0]        fpos_r;
  logic [POS_W-1:0]        fpos_nxt;

  logic                    accept;
  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] entry    [CAPACITY];
  logic [CAPACITY-1:0]     le;
  logic [CAPACITY-1:0]     eq;
  logic [CAPACITY-1:0]     first_eq;
  logic [CAPACITY-1:0]     ins_here;
  logic [IDX_W-1:0]        eq_idx;
  logic [IDX_W-1:0]        ins_idx;
  logic signed [VAL_W-1:0] rd_val;
  logic                    found;
  logic                    full;
  logic                    pos_ok;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  // operation decode
  always_comb begin
    full        = count_r == CNT_W'(CAPACITY);
    found       = |eq;
    pos_ok      = CNT_W'(in_ch.position) < count_r;
    if (POS_W > CNT_W) begin
      pos_ok    = {{CNT_W{1'b0}}, in_ch.position} < {{POS_W{1'b0}}, count_r};
    end
    ctrl.value  = in_ch.value;
    ctrl.pos    = in_ch.position;
    ctrl.ins_en = accept && (in_ch.op == OP_INSERT) && !full;
    ctrl.rv_en  = accept && (in_ch.op == OP_REMOVE_VAL) && found;
    ctrl.rp_en  = accept && (in_ch.op == OP_REMOVE_POS) && pos_ok;
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_le;
    logic                    left_eq;
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_le  = 1'b1;
      assign left_eq  = 1'b0;
      assign left_val = in_ch.value;
    end else begin : g_body
      assign left_le  = le[i-1];
      assign left_eq  = eq[i-1];
      assign left_val = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = entry[i];
    end else begin : g_next
      assign right_val = entry[i+1];
    end

    sle_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (IDX_W'(i)),
      .count     (count_r),
      .left_le   (left_le),
      .left_eq   (left_eq),
      .left_val  (left_val),
      .right_val (right_val),
      .entry     (entry[i]),
      .le        (le[i]),
      .eq        (eq[i]),
      .first_eq  (first_eq[i]),
      .ins_here  (ins_here[i])
    );
  end

  // encode one-hot marks and select the read entry
  always_comb begin
    eq_idx  = '0;
    ins_idx = '0;
    rd_val  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_eq[i]) eq_idx  = eq_idx | IDX_W'(i);
      if (ins_here[i]) ins_idx = ins_idx | IDX_W'(i);
      if (CMP_W'(i) == CMP_W'(in_ch.position)) rd_val = rd_val | entry[i];
    end
  end

  // result and length update
  always_comb begin
    status_nxt = ST_OK;
    fval_nxt   = '0;
    fpos_nxt   = '0;
    count_nxt  = count_r;
    case (in_ch.op)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          fpos_nxt  = idx_to_pos(ins_idx);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE_VAL: begin
        if (!found) begin
          status_nxt = ST_MISSING;
        end else begin
          fpos_nxt  = idx_to_pos(eq_idx);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_REMOVE_POS: begin
        if (!pos_ok) begin
          status_nxt = ST_RANGE;
        end else begin
          fpos_nxt  = in_ch.position;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (!found) begin
          status_nxt = ST_MISSING;
        end else begin
          fpos_nxt = idx_to_pos(eq_idx);
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          status_nxt = ST_RANGE;
        end else begin
          fpos_nxt = in_ch.position;
          fval_nxt = rd_val;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (in_ch.ready) begin
        out_valid_r <= in_ch.valid;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      fval_r   <= fval_nxt;
      fpos_r   <= fpos_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.found_value    = fval_r;
  assign out_ch.found_position = fpos_r;
  assign out_ch.length         = cnt_to_len(count_r);
  assign out_ch.empty_res      = count_r == '0;

endmodule

[design/sle_checker.sv]
`timescale 1ns / 1ps

module sle_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sle_pkg::status_t    out_status,
  input  logic signed [31:0]  out_found_value,
  input  logic [5:0]          out_length,
  input  logic                out_empty_res
);
  import sle_pkg::*;

  // output register is empty right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // empty flag agrees with the reported length
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_length == '0)))
    else $error("empty flag disagrees with length");

  // a full refusal only happens at capacity
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_length == LEN_W'(CAPACITY)))
    else $error("full status below capacity");

  // a read value can only come from a non-empty list
  a_empty_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> (out_found_value == '0))
    else $error("value reported from an empty list");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_length)))
    else $error("stalled result changed");

endmodule

bind sorted_list_engine_top sle_checker u_sle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_value (out_ch.found_value),
  .out_length      (out_ch.length),
  .out_empty_res   (out_ch.empty_res)
);
